[design/dmr_pkg.sv]
// ============================================================================
// dmr_pkg: shared types and constants for the dual motor ramp PWM unit
// Field widths, speed limit, item kinds and register indexes used by the
// top level and the per-motor ramp and duty slice.
// ============================================================================
package dmr_pkg;

    localparam int SPEED_W    = 16;     // signed Q8.8 percent
    localparam int STEP_W     = 15;     // ramp step, unsigned Q7.8 percent
    localparam int OFFSET_W   = 10;     // duty offset counts
    localparam int DUTY_W     = 12;     // duty counts
    localparam int MAG_W      = 15;     // |speed| never exceeds the limit
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;     // widest register
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;

    localparam logic signed [SPEED_W-1:0] SPEED_LIMIT = 16'sd25600;

    localparam logic [STEP_W-1:0]   RAMP_STEP_RESET   = 15'd256;
    localparam logic [OFFSET_W-1:0] DUTY_OFFSET_RESET = 10'd50;

    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic [DUTY_W-1:0]         duty_t;

    typedef enum logic
    {
        MODE_SET  = 1'b0,
        MODE_TICK = 1'b1
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_RAMP_STEP   = 1'b0,
        CFG_DUTY_OFFSET = 1'b1
    } cfg_idx_t;

    // Result of one motor's ramp and duty slice.
    typedef struct packed
    {
        speed_t speed;
        duty_t  rev_duty;
        duty_t  fwd_duty;
    } motor_out_t;

endpackage

[design/dmr_motor_slice.sv]
// ============================================================================
// dmr_motor_slice: ramp and duty logic for one motor
// Moves the current speed toward the target by at most one step without
// passing it, then forms the forward and reverse duty from the new speed.
// ============================================================================
module dmr_motor_slice
(
    input  dmr_pkg::speed_t                   cur_speed,
    input  dmr_pkg::speed_t                   tgt_speed,
    input  logic [dmr_pkg::STEP_W-1:0]        ramp_step,
    input  logic [dmr_pkg::OFFSET_W-1:0]      duty_offset,
    output dmr_pkg::motor_out_t               result
);
    import dmr_pkg::*;

    localparam int WIDE_W = SPEED_W + 2;
    localparam int PROD_W = MAG_W + 5;

    logic signed [WIDE_W-1:0] cur_w;
    logic signed [WIDE_W-1:0] tgt_w;
    logic signed [WIDE_W-1:0] step_w;
    logic signed [WIDE_W-1:0] up_w;
    logic signed [WIDE_W-1:0] dn_w;
    logic signed [WIDE_W-1:0] new_w;
    speed_t                   new_speed;
    logic signed [SPEED_W:0]  abs_w;
    logic [MAG_W-1:0]         mag;
    logic [PROD_W-1:0]        prod;
    duty_t                    drive;
    duty_t                    offset_duty;

    assign cur_w  = WIDE_W'(cur_speed);
    assign tgt_w  = WIDE_W'(tgt_speed);
    assign step_w = $signed({{(WIDE_W-STEP_W){1'b0}}, ramp_step});
    assign up_w   = cur_w + step_w;
    assign dn_w   = cur_w - step_w;

    always_comb
    begin
        priority if (cur_w < tgt_w)
        begin
            new_w = (up_w < tgt_w) ? up_w : tgt_w;
        end
        else if (cur_w > tgt_w)
        begin
            new_w = (dn_w > tgt_w) ? dn_w : tgt_w;
        end
        else
        begin
            new_w = cur_w;
        end
    end

    // The new speed always lies between the old one and the target.
    assign new_speed = new_w[SPEED_W-1:0];

    assign abs_w = new_speed[SPEED_W-1] ? -(SPEED_W+1)'(new_speed)
                                        : (SPEED_W+1)'(new_speed);
    assign mag   = abs_w[MAG_W-1:0];

    // Times 24 as (x << 4) + (x << 3); dropping eight bits truncates.
    assign prod = ({{(PROD_W-MAG_W){1'b0}}, mag} << 4)
                + ({{(PROD_W-MAG_W){1'b0}}, mag} << 3);

    assign offset_duty = {{(DUTY_W-OFFSET_W){1'b0}}, duty_offset};
    assign drive       = prod[PROD_W-1:8] + offset_duty;

    always_comb
    begin
        result.speed = new_speed;
        if (new_speed > 0)
        begin
            result.fwd_duty = drive;
            result.rev_duty = offset_duty;
        end
        else if (new_speed < 0)
        begin
            result.fwd_duty = offset_duty;
            result.rev_duty = drive;
        end
        else
        begin
            result.fwd_duty = offset_duty;
            result.rev_duty = offset_duty;
        end
    end

endmodule

[design/dual_motor_ramp_pwm_unit.sv]
// ============================================================================
// dual_motor_ramp_pwm_unit: slew-rate-limited speed ramp for two motors
// Holds a target and a current speed per motor, ramps them on tick items
// and returns four duty values and both current speeds per tick.
// ============================================================================
//
//  Channel   Direction  Handshake              Payload
//  s_axis    in         tvalid / tready        tdata: target_speed
//                                              tuser: mode, motor_sel
//  m_axis    out        tvalid / tready        tdata: four duties, two speeds
//  cfg       in         cfg_we (no wait)       cfg_index, cfg_data
//
// Each transfer is captured in an input register; from there the ramp and
// duty logic runs and a tick result lands in the output register, which
// offers it.  One item is taken per cycle sustained while the output side
// accepts results; the state update is a single add, compare and constant
// multiply pass in the second stage.  Set items give no result.
// Reset clears all speeds and loads the register defaults.  While a result
// waits in the output register a tick holds in the input register; set
// items still pass and an empty input register still takes a transfer.
//
module dual_motor_ramp_pwm_unit
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] target_speed
    input  logic [dmr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] mode, [1] motor_sel
    input  logic [dmr_pkg::IN_USER_W-1:0]      s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [11:0] left_fwd_duty, [23:12] left_rev_duty, [35:24] right_fwd_duty,
    // [47:36] right_rev_duty, [63:48] left_speed_now, [79:64] right_speed_now
    output logic [dmr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,

    input  logic                               cfg_we,
    input  logic [dmr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dmr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dmr_pkg::*;

    // Configuration registers.
    logic [STEP_W-1:0]   ramp_step_reg;
    logic [OFFSET_W-1:0] duty_offset_reg;

    // Input stage.
    logic   in_valid_reg;
    mode_t  in_mode_reg;
    logic   in_sel_reg;
    speed_t in_target_reg;

    // Motor state.
    speed_t left_tgt_reg;
    speed_t right_tgt_reg;
    speed_t left_cur_reg;
    speed_t right_cur_reg;

    // Output stage.
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic       out_free;
    logic       in_go;
    logic       is_tick;
    speed_t     target_sat;
    motor_out_t left_res;
    motor_out_t right_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_step_reg   <= RAMP_STEP_RESET;
            duty_offset_reg <= DUTY_OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RAMP_STEP:   ramp_step_reg   <= cfg_data[STEP_W-1:0];
                CFG_DUTY_OFFSET: duty_offset_reg <= cfg_data[OFFSET_W-1:0];
                default:         ramp_step_reg   <= ramp_step_reg;
            endcase
        end
    end

    // A set item always leaves the input stage; a tick needs room downstream.
    assign is_tick       = (in_mode_reg == MODE_TICK);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_go         = in_valid_reg && (!is_tick || out_free);
    assign s_axis_tready = !in_valid_reg || in_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_mode_reg   <= mode_t'(s_axis_tuser[0]);
            in_sel_reg    <= s_axis_tuser[1];
            in_target_reg <= s_axis_tdata[SPEED_W-1:0];
        end
    end

    // New targets are limited to plus or minus full speed when written.
    always_comb
    begin
        priority if (in_target_reg > SPEED_LIMIT)
        begin
            target_sat = SPEED_LIMIT;
        end
        else if (in_target_reg < -SPEED_LIMIT)
        begin
            target_sat = -SPEED_LIMIT;
        end
        else
        begin
            target_sat = in_target_reg;
        end
    end

    dmr_motor_slice u_left
    (
        .cur_speed   (left_cur_reg),
        .tgt_speed   (left_tgt_reg),
        .ramp_step   (ramp_step_reg),
        .duty_offset (duty_offset_reg),
        .result      (left_res)
    );

    dmr_motor_slice u_right
    (
        .cur_speed   (right_cur_reg),
        .tgt_speed   (right_tgt_reg),
        .ramp_step   (ramp_step_reg),
        .duty_offset (duty_offset_reg),
        .result      (right_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_tgt_reg  <= '0;
            right_tgt_reg <= '0;
            left_cur_reg  <= '0;
            right_cur_reg <= '0;
        end
        else if (in_go)
        begin
            if (is_tick)
            begin
                left_cur_reg  <= left_res.speed;
                right_cur_reg <= right_res.speed;
            end
            else if (in_sel_reg)
            begin
                right_tgt_reg <= target_sat;
            end
            else
            begin
                left_tgt_reg <= target_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_go && is_tick;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_go && is_tick)
        begin
            out_data_reg <= {right_res.speed, left_res.speed,
                             right_res.rev_duty, right_res.fwd_duty,
                             left_res.rev_duty, left_res.fwd_duty};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A set item never produces a result.
    a_set_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_go && !is_tick && !out_valid_reg) |=> !out_valid_reg)
        else $error("set item produced a result");

    // A tick that leaves the input stage always shows up as a result.
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_go && is_tick) |=> out_valid_reg)
        else $error("tick result lost");

    // Current speeds never leave the full-speed range.
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        (left_cur_reg <= SPEED_LIMIT) && (left_cur_reg >= -SPEED_LIMIT)
        && (right_cur_reg <= SPEED_LIMIT) && (right_cur_reg >= -SPEED_LIMIT))
        else $error("current speed out of range");

    // The left motor, when already at its target, stays there on a tick.
    a_hold_at_target: assert property (@(posedge clk) disable iff (!rst_n)
        (in_go && is_tick && (left_cur_reg == left_tgt_reg)) |=> $stable(left_cur_reg))
        else $error("left speed moved away from its target");

    // The input side only stalls while an item is held in the input stage.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && is_tick && out_valid_reg))
        else $error("input stalled without a waiting tick");

endmodule
